@@ rtl/core/html_char_reference_decoder_unit_defines.svh @@
// assertion helpers for the decoder rtl
`ifndef HTML_CHAR_REFERENCE_DECODER_UNIT_DEFINES_SVH
`define HTML_CHAR_REFERENCE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HCRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hcrd_pkg.sv @@
`default_nettype none

package hcrd_pkg;

  localparam logic [20:0] CP_REPL = 21'h00FFFD;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] CP_SAT  = 21'h110000;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] C1_LO   = 21'h000080;
  localparam logic [20:0] C1_HI   = 21'h00009F;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int N_ENT  = 37;

  typedef struct packed {
    logic       alnum;
    logic       is_dec;
    logic       is_hexl;
    logic       semi;
    logic       hash;
    logic       xch;
    logic       amp;
    logic [3:0] dval;
  } cls_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       eos;
    cls_t       cls;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } head_t;

  typedef struct packed {
    logic p_open;
    logic flushing;
  } back_stat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        from_reference;
    logic        missing_semicolon;
  } res_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] cp;
  } ent_hit_t;

  typedef enum logic [4:0] {
    PH_TEXT = 5'b00001,
    PH_AMP  = 5'b00010,
    PH_NUM  = 5'b00100,
    PH_NAME = 5'b01000,
    PH_RPL  = 5'b10000
  } phase_t;

  // windows-1252 remap of 0x80-0x9f
  localparam logic [15:0] C1_MAP [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  // names right-justified, first character in the highest used byte
  localparam logic [47:0] ENT_TXT [N_ENT] = '{
    "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
    "trade", "hellip", "mdash", "ndash", "laquo", "raquo", "times", "divide",
    "middot", "bull", "dagger", "Dagger", "permil", "prime", "Prime", "lsaquo",
    "rsaquo", "oline", "frasl", "euro", "deg", "plusmn", "para", "sect",
    "larr", "uarr", "rarr", "darr", "harr"
  };

  localparam logic [2:0] ENT_LEN [N_ENT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3,
    3'd5, 3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6,
    3'd6, 3'd4, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd6,
    3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd6, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam logic [15:0] ENT_CP [N_ENT] = '{
    16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h00A0, 16'h00A9, 16'h00AE,
    16'h2122, 16'h2026, 16'h2014, 16'h2013, 16'h00AB, 16'h00BB, 16'h00D7, 16'h00F7,
    16'h00B7, 16'h2022, 16'h2020, 16'h2021, 16'h2030, 16'h2032, 16'h2033, 16'h2039,
    16'h203A, 16'h203E, 16'h2044, 16'h20AC, 16'h00B0, 16'h00B1, 16'h00B6, 16'h00A7,
    16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h2194
  };

  function automatic logic [20:0] map_number(input logic [20:0] v);
    logic [20:0] r;
    r = v;
    if (v == '0 || v > CP_MAX || (v >= SURR_LO && v <= SURR_HI)) begin
      r = CP_REPL;
    end else if (v >= C1_LO && v <= C1_HI) begin
      r = {5'd0, C1_MAP[v[4:0]]};
    end
    return r;
  endfunction

  function automatic ent_hit_t ent_lookup(input logic [47:0] pk, input logic [4:0] len);
    ent_hit_t r;
    r = '0;
    for (int e = 0; e < N_ENT; e++) begin
      if (len == {2'b00, ENT_LEN[e]} && pk == ENT_TXT[e]) begin
        r.hit = 1'b1;
        r.cp  = ENT_CP[e];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hcrd_chan_if.sv @@
`default_nettype none

interface hcrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_span;
  modport source (output valid, output byte_value, output end_of_span, input ready);
  modport sink   (input valid, input byte_value, input end_of_span, output ready);
endinterface

interface hcrd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        from_reference;
  logic        missing_semicolon;
  logic        last_of_run;
  logic        span_done;
  modport source (output valid, output code_point, output from_reference,
                  output missing_semicolon, output last_of_run, output span_done,
                  input ready);
  modport sink   (input valid, input code_point, input from_reference,
                  input missing_semicolon, input last_of_run, input span_done,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/hcrd_front.sv @@
`default_nettype none

module hcrd_front (
  input  logic              clk,
  input  logic              rst_n,
  hcrd_in_if.sink           in_ch,
  input  logic              pop,
  output hcrd_pkg::head_t   head
);

  hcrd_pkg::q_item_t                q_r [hcrd_pkg::QDEPTH];
  logic [hcrd_pkg::QAW-1:0]         wp_r;
  logic [hcrd_pkg::QAW-1:0]         rp_r;
  logic [hcrd_pkg::QAW:0]           cnt_r;
  logic [hcrd_pkg::QAW:0]           cnt_nxt;
  logic                             push;
  logic [7:0]                       b;
  hcrd_pkg::cls_t                   cls;
  logic                             lower;
  logic                             upper;

  // byte classes for the decoder
  assign b     = in_ch.byte_value;
  assign lower = (b >= 8'h61) && (b <= 8'h7A);
  assign upper = (b >= 8'h41) && (b <= 8'h5A);

  always_comb begin
    cls         = '0;
    cls.is_dec  = (b >= 8'h30) && (b <= 8'h39);
    cls.is_hexl = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    cls.alnum   = cls.is_dec || lower || upper;
    cls.semi    = (b == hcrd_pkg::CH_SEMI);
    cls.hash    = (b == hcrd_pkg::CH_HASH);
    cls.xch     = (b == 8'h78) || (b == 8'h58);
    cls.amp     = (b == hcrd_pkg::CH_AMP);
    cls.dval    = cls.is_dec ? b[3:0] : 4'(b[3:0] + 4'd9);
  end

  assign in_ch.ready = (cnt_r != (hcrd_pkg::QAW+1)'(hcrd_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{byte_value: b, eos: in_ch.end_of_span, cls: cls};
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

endmodule

`default_nettype wire

@@ rtl/core/hcrd_back.sv @@
`default_nettype none

module hcrd_back #(
  parameter int MAX_NAME_LENGTH = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hcrd_pkg::head_t        head,
  output logic                   pop,
  output hcrd_pkg::back_stat_t   stat,
  hcrd_out_if.source             out_ch
);

  localparam int CW = $clog2(MAX_NAME_LENGTH + 1);
  localparam int AW = $clog2(MAX_NAME_LENGTH);

  // decoder state
  hcrd_pkg::phase_t phase_r, phase_nxt;
  logic             hex_r, hex_nxt;
  logic             dseen_r, dseen_nxt;
  logic [20:0]      num_r, num_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic [20:0]      part_r, part_nxt;
  logic             rph_r, rph_nxt;
  logic [CW-1:0]    ridx_r, ridx_nxt;
  logic             fl_r, fl_nxt;
  logic [7:0]       nb_r [MAX_NAME_LENGTH];
  logic             nb_we;
  logic [AW-1:0]    nb_wa;

  // output staging
  logic             o_valid_r, o_valid_nxt;
  hcrd_pkg::res_t   o_res_r, o_res_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_done_r, o_done_nxt;
  logic             o_load;
  logic             p_valid_r, p_valid_nxt;
  logic             p_closed_r, p_closed_nxt;
  logic             p_done_r, p_done_nxt;
  hcrd_pkg::res_t   p_res_r, p_res_nxt;

  logic [7:0]       b;
  hcrd_pkg::cls_t   c;
  logic             eos;
  logic             o_free;
  logic             step_go;
  logic             emit;
  hcrd_pkg::res_t   em;
  logic             consumed;
  logic             fin;
  logic             idle_after;
  logic             rpl_go;
  logic             rpl_hash;
  logic             do_clear;
  logic             digit;
  logic [24:0]      num_mul;
  logic [24:0]      num_sum;
  logic [20:0]      num_acc;
  logic [20:0]      num_cp;
  logic [47:0]      pk;
  hcrd_pkg::ent_hit_t ent;
  logic [20:0]      nv;
  logic             u_ok;
  logic [7:0]       rpl_ch;
  logic [CW-1:0]    ridx_inc;
  logic             more;

  assign b   = head.item.byte_value;
  assign c   = head.item.cls;
  assign eos = head.item.eos;

  assign o_free  = !o_valid_r || out_ch.ready;
  assign step_go = head.valid && o_free;

  // digit accumulation, saturating above the unicode range
  assign digit   = c.is_dec || (hex_r && c.is_hexl);
  assign num_mul = hex_r ? 25'({num_r, 4'b0000})
                         : 25'({num_r, 3'b000}) + 25'({num_r, 1'b0});
  assign num_sum = num_mul + 25'(c.dval);
  assign num_acc = (num_sum > 25'(hcrd_pkg::CP_MAX)) ? hcrd_pkg::CP_SAT : num_sum[20:0];
  assign num_cp  = hcrd_pkg::map_number(num_r);

  // named lookup over the first name bytes
  always_comb begin
    pk = '0;
    for (int k = 0; k < 6; k++) begin
      if (CW'(k) < cnt_r) pk = {pk[39:0], nb_r[k]};
    end
  end
  assign ent = hcrd_pkg::ent_lookup(pk, 5'(cnt_r));

  // utf-8 continuation check
  assign nv = {part_r[14:0], b[5:0]};
  always_comb begin
    u_ok = (b[7:6] == 2'b10);
    if (rem_r == 2'd3) begin
      u_ok = u_ok && (nv >= 21'h10) && (nv <= 21'h10F);
    end else if (rem_r == 2'd2 && part_r < 21'h10) begin
      u_ok = u_ok && (nv >= 21'h20) && !((nv >= 21'h360) && (nv <= 21'h37F));
    end
  end

  // replay of buffered bytes
  assign ridx_inc = ridx_r + CW'(1);
  assign rpl_ch   = rph_r ? hcrd_pkg::CH_HASH : nb_r[ridx_r[AW-1:0]];
  assign more     = rph_r ? (cnt_r != '0) : (ridx_inc < cnt_r);

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    dseen_nxt = dseen_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    part_nxt  = part_r;
    rph_nxt   = rph_r;
    ridx_nxt  = ridx_r;
    fl_nxt    = fl_r;
    nb_we     = 1'b0;
    nb_wa     = '0;
    emit      = 1'b0;
    em        = '0;
    consumed  = 1'b0;
    rpl_go    = 1'b0;
    rpl_hash  = 1'b0;
    do_clear  = 1'b0;

    unique case (phase_r)
      hcrd_pkg::PH_RPL: begin
        emit          = 1'b1;
        em.code_point = {13'd0, rpl_ch};
        if (rph_r) rph_nxt  = 1'b0;
        else       ridx_nxt = ridx_inc;
        if (!more) do_clear = 1'b1;
      end
      hcrd_pkg::PH_AMP: begin
        if (fl_r) begin
          rpl_go = 1'b1;
        end else if (c.hash) begin
          phase_nxt = hcrd_pkg::PH_NUM;
          consumed  = 1'b1;
        end else if (c.alnum) begin
          nb_we     = 1'b1;
          cnt_nxt   = CW'(1);
          phase_nxt = hcrd_pkg::PH_NAME;
          consumed  = 1'b1;
        end else begin
          rpl_go = 1'b1;
        end
      end
      hcrd_pkg::PH_NUM: begin
        if (fl_r) begin
          if (dseen_r) begin
            emit                 = 1'b1;
            em.code_point        = num_cp;
            em.from_reference    = 1'b1;
            em.missing_semicolon = 1'b1;
            do_clear             = 1'b1;
          end else begin
            rpl_go   = 1'b1;
            rpl_hash = 1'b1;
          end
        end else if (digit) begin
          num_nxt   = num_acc;
          dseen_nxt = 1'b1;
          consumed  = 1'b1;
        end else if (c.xch && !dseen_r && !hex_r) begin
          hex_nxt  = 1'b1;
          nb_we    = 1'b1;
          cnt_nxt  = CW'(1);
          consumed = 1'b1;
        end else if (dseen_r) begin
          emit                 = 1'b1;
          em.code_point        = num_cp;
          em.from_reference    = 1'b1;
          em.missing_semicolon = !c.semi;
          do_clear             = 1'b1;
          consumed             = c.semi;
        end else begin
          rpl_go   = 1'b1;
          rpl_hash = 1'b1;
        end
      end
      hcrd_pkg::PH_NAME: begin
        if (fl_r) begin
          rpl_go = 1'b1;
        end else if (c.alnum && cnt_r < CW'(MAX_NAME_LENGTH)) begin
          nb_we    = 1'b1;
          nb_wa    = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
          consumed = 1'b1;
        end else if (c.semi && ent.hit) begin
          emit              = 1'b1;
          em.code_point     = {5'd0, ent.cp};
          em.from_reference = 1'b1;
          do_clear          = 1'b1;
          consumed          = 1'b1;
        end else begin
          rpl_go = 1'b1;
        end
      end
      hcrd_pkg::PH_TEXT: begin
        if (fl_r) begin
          if (rem_r != 2'd0) begin
            emit          = 1'b1;
            em.code_point = hcrd_pkg::CP_REPL;
            rem_nxt       = 2'd0;
            part_nxt      = '0;
          end
        end else if (rem_r != 2'd0) begin
          if (u_ok) begin
            part_nxt = nv;
            rem_nxt  = rem_r - 2'd1;
            consumed = 1'b1;
            if (rem_r == 2'd1) begin
              emit          = 1'b1;
              em.code_point = nv;
              part_nxt      = '0;
            end
          end else begin
            emit          = 1'b1;
            em.code_point = hcrd_pkg::CP_REPL;
            rem_nxt       = 2'd0;
            part_nxt      = '0;
          end
        end else if (c.amp) begin
          phase_nxt = hcrd_pkg::PH_AMP;
          consumed  = 1'b1;
        end else if (!b[7]) begin
          emit          = 1'b1;
          em.code_point = {13'd0, b};
          consumed      = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          part_nxt = {16'd0, b[4:0]};
          rem_nxt  = 2'd1;
          consumed = 1'b1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          part_nxt = {17'd0, b[3:0]};
          rem_nxt  = 2'd2;
          consumed = 1'b1;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          part_nxt = {18'd0, b[2:0]};
          rem_nxt  = 2'd3;
          consumed = 1'b1;
        end else begin
          emit          = 1'b1;
          em.code_point = hcrd_pkg::CP_REPL;
          consumed      = 1'b1;
        end
      end
      default: phase_nxt = hcrd_pkg::PH_TEXT;
    endcase

    // failed reference: '&', any '#', the buffer; one per free cycle
    if (rpl_go) begin
      emit          = 1'b1;
      em            = '0;
      em.code_point = {13'd0, hcrd_pkg::CH_AMP};
      phase_nxt     = hcrd_pkg::PH_RPL;
      rph_nxt       = rpl_hash;
      ridx_nxt      = '0;
      if (!rpl_hash && cnt_r == '0) do_clear = 1'b1;
    end

    if (do_clear) begin
      phase_nxt = hcrd_pkg::PH_TEXT;
      hex_nxt   = 1'b0;
      dseen_nxt = 1'b0;
      num_nxt   = '0;
      cnt_nxt   = '0;
      rph_nxt   = 1'b0;
      ridx_nxt  = '0;
    end

    idle_after = (phase_nxt == hcrd_pkg::PH_TEXT) && (rem_nxt == 2'd0);
    fin        = fl_r ? idle_after : (consumed && (!eos || idle_after));
    if (!fl_r && consumed && eos && !idle_after) fl_nxt = 1'b1;
    if (fin) fl_nxt = 1'b0;
  end

  // pending result waits until we know whether it closes the byte
  always_comb begin
    o_load       = 1'b0;
    o_res_nxt    = o_res_r;
    o_last_nxt   = o_last_r;
    o_done_nxt   = o_done_r;
    p_valid_nxt  = p_valid_r;
    p_closed_nxt = p_closed_r;
    p_done_nxt   = p_done_r;
    p_res_nxt    = p_res_r;
    if (o_free) begin
      if (p_valid_r && (p_closed_r || (step_go && (emit || fin)))) begin
        o_load     = 1'b1;
        o_res_nxt  = p_res_r;
        o_last_nxt = p_closed_r ? 1'b1 : !emit;
        o_done_nxt = p_closed_r ? p_done_r : (!emit && eos);
        if (step_go && emit) begin
          p_valid_nxt  = 1'b1;
          p_res_nxt    = em;
          p_closed_nxt = fin;
          p_done_nxt   = fin && eos;
        end else begin
          p_valid_nxt  = 1'b0;
          p_closed_nxt = 1'b0;
        end
      end else if (step_go && emit) begin
        if (fin) begin
          o_load     = 1'b1;
          o_res_nxt  = em;
          o_last_nxt = 1'b1;
          o_done_nxt = eos;
        end else begin
          p_valid_nxt  = 1'b1;
          p_res_nxt    = em;
          p_closed_nxt = 1'b0;
          p_done_nxt   = 1'b0;
        end
      end
    end
    o_valid_nxt = o_load || (o_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hcrd_pkg::PH_TEXT;
      hex_r      <= 1'b0;
      dseen_r    <= 1'b0;
      num_r      <= '0;
      cnt_r      <= '0;
      rem_r      <= 2'd0;
      part_r     <= '0;
      rph_r      <= 1'b0;
      ridx_r     <= '0;
      fl_r       <= 1'b0;
      o_valid_r  <= 1'b0;
      p_valid_r  <= 1'b0;
      p_closed_r <= 1'b0;
    end else begin
      if (step_go) begin
        phase_r <= phase_nxt;
        hex_r   <= hex_nxt;
        dseen_r <= dseen_nxt;
        num_r   <= num_nxt;
        cnt_r   <= cnt_nxt;
        rem_r   <= rem_nxt;
        part_r  <= part_nxt;
        rph_r   <= rph_nxt;
        ridx_r  <= ridx_nxt;
        fl_r    <= fl_nxt;
      end
      o_valid_r  <= o_valid_nxt;
      p_valid_r  <= p_valid_nxt;
      p_closed_r <= p_closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && nb_we) nb_r[nb_wa] <= b;
    if (o_load) begin
      o_res_r  <= o_res_nxt;
      o_last_r <= o_last_nxt;
      o_done_r <= o_done_nxt;
    end
    p_res_r  <= p_res_nxt;
    p_done_r <= p_done_nxt;
  end

  assign pop = step_go && fin;

  assign stat.p_open   = p_valid_r && !p_closed_r;
  assign stat.flushing = fl_r;

  assign out_ch.valid             = o_valid_r;
  assign out_ch.code_point        = o_res_r.code_point;
  assign out_ch.from_reference    = o_res_r.from_reference;
  assign out_ch.missing_semicolon = o_res_r.missing_semicolon;
  assign out_ch.last_of_run       = o_last_r;
  assign out_ch.span_done         = o_done_r;

endmodule

`default_nettype wire

@@ rtl/core/html_char_reference_decoder_unit.sv @@
// a plain byte is written into the front queue, decoded at the queue head and registered in the output stage for out_ch
// throughput: one byte per cycle while out_ch is not stalled, bounded by the one-step-per-cycle decode sequencer
// a failed reference replays its bytes one per step ('&', '#', name bytes)
// a span end with an open reference or utf-8 sequence adds a flush step after its last byte
// rst_n is synchronous, active low: clears queue, decoder state and output stage
`default_nettype none

`include "html_char_reference_decoder_unit_defines.svh"

module html_char_reference_decoder_unit #(
  parameter int MAX_NAME_LENGTH = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  hcrd_in_if.sink     in_ch,
  hcrd_out_if.source  out_ch
);

  // front: 4-entry byte queue with per-byte classification
  // back: decode sequencer, one step per cycle when a byte waits and out_ch is free,
  // plus a pending result register so last_of_run can be settled without looking ahead
  hcrd_pkg::head_t       head;
  hcrd_pkg::back_stat_t  stat;
  logic                  pop;

  hcrd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // the back holds the head byte until its last result has been decoded,
  // then pops it; a transfer on out_ch and a new step can share a cycle
  hcrd_back #(
    .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .stat   (stat),
    .out_ch (out_ch)
  );

  // an open pending result always belongs to the byte still at the queue head
  `HCRD_ASSERT_IMPL(a_open_has_byte, stat.p_open, head.valid, "pending result without byte")

  // the end-of-span flush only runs on the span's last byte
  `HCRD_ASSERT_IMPL(a_flush_on_end, stat.flushing, head.valid && head.item.eos, "flush off span end")

  // popping a byte finishes any flush in progress
  `HCRD_ASSERT_NEXT(a_pop_ends_flush, pop, !stat.flushing, "flush survived pop")

  // the final result of a span is also the last of its byte
  `HCRD_ASSERT_IMPL(a_done_is_last, out_ch.valid && out_ch.span_done, out_ch.last_of_run,
    "span_done without last_of_run")

endmodule

`default_nettype wire

@@ verif/hcrd_tb_chan_if.sv @@
`timescale 1ns / 100ps

// channel interfaces are taken from the rtl file hcrd_chan_if.sv; this file only
// holds the replacement code-point constant for the bench
package hcrd_tb_pkg;
  localparam logic [20:0] TB_REPL = 21'h00FFFD;
endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [20:0] cp;
    logic        from_ref;
    logic        semi;
    logic        last;
    logic        done;
  } cp_res_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       has_exp;
    logic [20:0] exp_cp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  hcrd_in_if  in_ch ();
  hcrd_out_if out_ch ();

  html_char_reference_decoder_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // decoder shadow state
  hcrd_pkg::phase_t sh_phase;
  logic        sh_hex, sh_dig;
  logic [20:0] sh_num;
  logic [7:0]  sh_name [6];
  int          sh_ncnt;
  int          sh_urem;
  logic [20:0] sh_upart;

  cp_res_t pending_cps [$];
  cp_res_t step_cps [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0, snk_stall_pct = 0;
  logic tb_fail = 1'b0;

  function automatic bit alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic int digit_val(logic [7:0] b, bit hex);
    if (b >= "0" && b <= "9") return b - "0";
    if (hex && b >= "a" && b <= "f") return b - "a" + 10;
    if (hex && b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic logic [20:0] num_to_cp(logic [20:0] v);
    logic [15:0] c1 [32];
    c1 = '{16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020,
           16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D,
           16'h017D, 16'h008F, 16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D,
           16'h2022, 16'h2013, 16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A,
           16'h0153, 16'h009D, 16'h017E, 16'h0178};
    if (v == 0 || v > 21'h10FFFF || (v >= 21'hD800 && v <= 21'hDFFF))
      return hcrd_tb_pkg::TB_REPL;
    if (v >= 21'h80 && v <= 21'h9F) return {5'd0, c1[v[4:0]]};
    return v;
  endfunction

  // named entity table, names as strings
  function automatic int name_lookup(output logic [20:0] cp);
    string nm [37];
    logic [15:0] cv [37];
    string s;
    nm = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg", "trade", "hellip",
           "mdash", "ndash", "laquo", "raquo", "times", "divide", "middot", "bull",
           "dagger", "Dagger", "permil", "prime", "Prime", "lsaquo", "rsaquo", "oline",
           "frasl", "euro", "deg", "plusmn", "para", "sect", "larr", "uarr", "rarr",
           "darr", "harr"};
    cv = '{16'h26, 16'h3C, 16'h3E, 16'h22, 16'h27, 16'hA0, 16'hA9, 16'hAE, 16'h2122,
           16'h2026, 16'h2014, 16'h2013, 16'hAB, 16'hBB, 16'hD7, 16'hF7, 16'hB7,
           16'h2022, 16'h2020, 16'h2021, 16'h2030, 16'h2032, 16'h2033, 16'h2039,
           16'h203A, 16'h203E, 16'h2044, 16'h20AC, 16'hB0, 16'hB1, 16'hB6, 16'hA7,
           16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h2194};
    s = "";
    for (int k = 0; k < sh_ncnt; k++) s = {s, string'(sh_name[k])};
    cp = '0;
    for (int e = 0; e < 37; e++) begin
      if (nm[e] == s) begin
        cp = {5'd0, cv[e]};
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void put_cp(logic [20:0] cp, logic fr, logic sm);
    step_cps.push_back('{cp, fr, sm, 1'b0, 1'b0});
  endfunction

  function automatic void drop_ref();
    sh_phase = hcrd_pkg::PH_TEXT;
    sh_hex = 0;
    sh_dig = 0;
    sh_num = '0;
    sh_ncnt = 0;
  endfunction

  // failed reference: '&', optional '#', then buffered bytes as literals
  function automatic void replay_literal(bit hash);
    put_cp(21'h26, 0, 0);
    if (hash) put_cp(21'h23, 0, 0);
    for (int k = 0; k < sh_ncnt; k++) put_cp({13'd0, sh_name[k]}, 0, 0);
    drop_ref();
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int d;
    logic [20:0] cp;
    logic [31:0] acc;
    logic [20:0] nv;
    bit ok;
    forever begin
      if (sh_phase == hcrd_pkg::PH_AMP) begin
        if (b == "#") begin
          drop_ref();
          sh_phase = hcrd_pkg::PH_NUM;
          return;
        end
        if (alnum(b)) begin
          sh_name[0] = b;
          sh_ncnt = 1;
          sh_phase = hcrd_pkg::PH_NAME;
          return;
        end
        replay_literal(0);
        continue;
      end
      if (sh_phase == hcrd_pkg::PH_NUM) begin
        d = digit_val(b, sh_hex);
        if (d >= 0) begin
          acc = sh_num * (sh_hex ? 16 : 10) + d;
          sh_num = (acc > 32'h10FFFF) ? 21'h110000 : acc[20:0];
          sh_dig = 1;
          return;
        end
        if (!sh_dig && !sh_hex && (b == "x" || b == "X")) begin
          sh_hex = 1;
          sh_name[0] = b;
          sh_ncnt = 1;
          return;
        end
        if (sh_dig) begin
          put_cp(num_to_cp(sh_num), 1, b != ";");
          drop_ref();
          if (b == ";") return;
          continue;
        end
        replay_literal(1);
        continue;
      end
      if (sh_phase == hcrd_pkg::PH_NAME) begin
        if (alnum(b) && sh_ncnt < 6) begin
          sh_name[sh_ncnt] = b;
          sh_ncnt++;
          return;
        end
        if (b == ";" && name_lookup(cp)) begin
          put_cp(cp, 1, 0);
          drop_ref();
          return;
        end
        replay_literal(0);
        continue;
      end
      // plain text: utf-8
      if (sh_urem > 0) begin
        ok = (b[7:6] == 2'b10);
        nv = {sh_upart[14:0], b[5:0]};
        if (ok && sh_urem == 3) ok = nv >= 21'h10 && nv <= 21'h10F;
        else if (ok && sh_urem == 2 && sh_upart < 21'h10)
          ok = nv >= 21'h20 && !(nv >= 21'h360 && nv <= 21'h37F);
        if (ok) begin
          sh_upart = nv;
          sh_urem--;
          if (sh_urem == 0) begin
            put_cp(sh_upart, 0, 0);
            sh_upart = '0;
          end
          return;
        end
        put_cp(hcrd_tb_pkg::TB_REPL, 0, 0);
        sh_urem = 0;
        sh_upart = '0;
        continue;
      end
      if (b == hcrd_pkg::CH_AMP) begin
        drop_ref();
        sh_phase = hcrd_pkg::PH_AMP;
      end else if (b < 8'h80) put_cp({13'd0, b}, 0, 0);
      else if (b >= 8'hC2 && b <= 8'hDF) begin
        sh_upart = {16'd0, b[4:0]};
        sh_urem = 1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        sh_upart = {17'd0, b[3:0]};
        sh_urem = 2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        sh_upart = {18'd0, b[2:0]};
        sh_urem = 3;
      end else put_cp(hcrd_tb_pkg::TB_REPL, 0, 0);
      return;
    end
  endfunction

  // predict the code points of one transfer and queue them
  function automatic void predict_byte(logic [7:0] b, logic eos);
    step_cps.delete();
    decode_byte(b);
    if (eos) begin
      if (sh_phase == hcrd_pkg::PH_AMP || sh_phase == hcrd_pkg::PH_NAME) replay_literal(0);
      else if (sh_phase == hcrd_pkg::PH_NUM) begin
        if (sh_dig) put_cp(num_to_cp(sh_num), 1, 1);
        else replay_literal(1);
      end else if (sh_urem > 0) put_cp(hcrd_tb_pkg::TB_REPL, 0, 0);
      drop_ref();
      sh_urem = 0;
      sh_upart = '0;
    end
    if (step_cps.size() > 0) begin
      step_cps[$].last = 1'b1;
      step_cps[$].done = eos;
    end
    foreach (step_cps[i]) pending_cps.push_back(step_cps[i]);
  endfunction

  // drive one byte; returns in the time step of its transfer
  task automatic send_byte(logic [7:0] b, logic eos);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.end_of_span <= eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, eos);
  endtask

  task automatic send_text(string s, logic eos_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos_last && i == s.len() - 1);
  endtask

  // receiver: random stall and compare against the oldest expected code point
  always @(posedge clk) begin
    cp_res_t got, want;
    if (rst_n) begin
      out_ch.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
      if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.code_point, out_ch.from_reference, out_ch.missing_semicolon,
                out_ch.last_of_run, out_ch.span_done};
        if (pending_cps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected code point %h", got.cp);
        end else begin
          want = pending_cps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp cp=%h ref=%b semi=%b last=%b done=%b,",
                        " got cp=%h ref=%b semi=%b last=%b done=%b"},
                       want.cp, want.from_ref, want.semi, want.last, want.done,
                       got.cp, got.from_ref, got.semi, got.last, got.done);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (idle_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed rows; expected code point typed in where obvious
  stim_row_t rows [$];
  function automatic void add_row(logic [7:0] b, logic eos, logic he, logic [20:0] cp);
    rows.push_back('{b, eos, he, cp});
  endfunction

  string frag [] = '{"&amp;", "&hellip;", "&#65;", "&#X1f600;", "&#128;", "&#0;",
                     "&#xD800;", "&#99999999;", "&#65", "&#;", "&#x;", "&abcdefgh;",
                     "&&amp;", "&#x9F", "\xE2\x82\xAC", "\xF0\x9F\x98\x80",
                     "\xE0\x80", "\xED\xA0", "\xF4\x90", "\xC3A", "\x80"};

  initial begin
    logic [7:0] b;
    int n;
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    in_ch.end_of_span = 1'b0;
    out_ch.ready = 1'b0;
    drop_ref();
    sh_urem = 0;
    sh_upart = '0;
    foreach (sh_name[i]) sh_name[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, single-byte spans and one two-byte span
    add_row(8'h00, 1, 1, 21'h0);
    add_row(8'h7F, 1, 1, 21'h7F);
    add_row(8'hFF, 1, 1, hcrd_tb_pkg::TB_REPL);
    add_row(8'hC0, 1, 1, hcrd_tb_pkg::TB_REPL);
    add_row(8'h80, 1, 1, hcrd_tb_pkg::TB_REPL);
    add_row(8'hC3, 1, 1, hcrd_tb_pkg::TB_REPL);
    add_row(hcrd_pkg::CH_AMP, 1, 1, 21'h26);
    add_row(8'h41, 0, 1, 21'h41);
    add_row(8'h3B, 1, 1, 21'h3B);
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].eos);
      if (rows[i].has_exp && (step_cps.size() == 0 || step_cps[0].cp !== rows[i].exp_cp))
      begin
        tb_fail = 1'b1;
        $display("predictor disagrees with table for byte %h", rows[i].b);
      end
    end
    foreach (frag[i]) send_text(frag[i], 1'b1);

    // random phases: fragments with random content plus noise
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 53; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 53; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(5))
          0: send_text(frag[$urandom_range(frag.size() - 1)], 1'($urandom_range(1)));
          1: send_text($sformatf("&#%0d;", $urandom_range(300)), 0);
          2: send_text($sformatf("&#x%0h", $urandom), 1'($urandom_range(1)));
          3: begin
            b = 8'($urandom);
            send_byte(b, $urandom_range(3) == 0);
          end
          4: send_text("&", 0);
          default: send_byte(8'(8'h20 + $urandom_range(94)), 0);
        endcase
      end
      send_byte(8'h2E, 1'b1);
    end
    in_ch.valid <= 1'b0;

    src_idle_pct = 0;
    snk_stall_pct = 0;
    n = 0;
    while (pending_cps.size() > 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_cps.size() == 0 && !tb_fail) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hcrd_pkg.sv
rtl/core/hcrd_chan_if.sv
rtl/core/hcrd_front.sv
rtl/core/hcrd_back.sv
rtl/core/html_char_reference_decoder_unit.sv
verif/hcrd_tb_chan_if.sv
verif/testbench.sv
